// ===== rtl/bpa_pkg.sv =====
// shared types and constants of the buddy page allocator
package bpa_pkg;

    localparam int MAX_POOL_ORDER   = 14;
    localparam int POOL_RESET_ORDER = 14;
    localparam int CFG_W            = 4;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [1:0] STATUS_REJECT   = 2'd2;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ORDER,
        ST_DISPATCH,
        ST_A_SCAN,
        ST_A_SPLIT,
        ST_A_FINISH,
        ST_RM_WRITE,
        ST_PUSH1,
        ST_PUSH2,
        ST_F_CHECK,
        ST_F_LOOP,
        ST_F_BUD,
        ST_F_CLR_BUD,
        ST_F_CLR_CUR
    } state_t;

    typedef struct packed {
        logic om;
        logic nx;
        logic pv;
    } mem_we_t;

endpackage

// ===== rtl/bpa_store.sv =====
// block order, free flag and list link memories with registered reads
module bpa_store #(
    parameter int MAX_POOL_ORDER = bpa_pkg::MAX_POOL_ORDER
) (
    input  logic                                clk,
    input  bpa_pkg::mem_we_t                    we,
    input  logic [MAX_POOL_ORDER-1:0]           om_waddr,
    input  logic [$clog2(MAX_POOL_ORDER + 1):0] om_wdata,
    input  logic [MAX_POOL_ORDER-1:0]           om_raddr,
    output logic [$clog2(MAX_POOL_ORDER + 1):0] om_rdata,
    input  logic [MAX_POOL_ORDER-1:0]           nx_waddr,
    input  logic [MAX_POOL_ORDER:0]             nx_wdata,
    input  logic [MAX_POOL_ORDER-1:0]           pv_waddr,
    input  logic [MAX_POOL_ORDER:0]             pv_wdata,
    input  logic [MAX_POOL_ORDER-1:0]           lk_raddr,
    output logic [MAX_POOL_ORDER:0]             nx_rdata,
    output logic [MAX_POOL_ORDER:0]             pv_rdata
);

    localparam int HW    = $clog2(MAX_POOL_ORDER + 1);
    localparam int OM_W  = HW + 1;
    localparam int DEPTH = 1 << MAX_POOL_ORDER;

    logic [OM_W-1:0]           om_mem [DEPTH];
    logic [MAX_POOL_ORDER:0]   nx_mem [DEPTH];
    logic [MAX_POOL_ORDER:0]   pv_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we.om)
        begin
            om_mem[om_waddr] <= om_wdata;
        end
        om_rdata <= om_mem[om_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (we.nx)
        begin
            nx_mem[nx_waddr] <= nx_wdata;
        end
        nx_rdata <= nx_mem[lk_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (we.pv)
        begin
            pv_mem[pv_waddr] <= pv_wdata;
        end
        pv_rdata <= pv_mem[lk_raddr];
    end

endmodule

// ===== rtl/buddy_page_allocator.sv =====
// buddy page allocator top level: sequencer, order lists and result registers
//
//  channel   signals                                        transfer
//  command   start, busy, op, page_count, block_index       start high and busy low
//  result    done, status, block_index_out, pages_free      done high, one cycle
//  config    cfg_valid, cfg_ready, cfg_data                 cfg_valid and cfg_ready high
//
// an allocation rounds the page count up to an order, scans the lists upward
// and splits the found block down to that order; a free rounds, checks the block
// and merges it with its buddy level by level until a buddy is not free or the pool order is reached
// the single read port per memory in the store sets the pace of every list step
// after reset and after each config transfer a clearing pass over all
// 2^MAX_POOL_ORDER entries runs with busy high; config is always taken
// results cannot be stalled by the receiver
module buddy_page_allocator #(
    parameter int MAX_POOL_ORDER = bpa_pkg::MAX_POOL_ORDER
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          op,
    input  logic [MAX_POOL_ORDER:0]       page_count,
    input  logic [MAX_POOL_ORDER-1:0]     block_index,
    output logic                          done,
    output logic [1:0]                    status,
    output logic [MAX_POOL_ORDER-1:0]     block_index_out,
    output logic [MAX_POOL_ORDER:0]       pages_free,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bpa_pkg::CFG_W-1:0]     cfg_data
);

    localparam int MX   = MAX_POOL_ORDER;
    localparam int HW   = $clog2(MX + 1);
    localparam int KW   = $clog2(MX + 2);
    localparam int OM_W = HW + 1;
    localparam int RST_ORD = (bpa_pkg::POOL_RESET_ORDER > MX) ? MX : bpa_pkg::POOL_RESET_ORDER;
    localparam logic [MX:0] NIL = {1'b1, {MX{1'b0}}};

    bpa_pkg::state_t   state_reg, state_next;
    logic              op_reg, op_next;
    logic [MX:0]       cnt_reg, cnt_next;
    logic [MX-1:0]     blk_reg, blk_next;
    logic [KW-1:0]     k_reg, k_next;
    logic [KW-1:0]     ord_reg, ord_next;
    logic [MX-1:0]     pg_reg, pg_next;
    logic [MX-1:0]     cur_reg, cur_next;
    logic [MX-1:0]     bud_reg, bud_next;
    logic [HW-1:0]     po_reg, po_next;
    logic [MX:0]       ftot_reg, ftot_next;
    logic [MX-1:0]     clr_reg, clr_next;
    logic              done_reg, done_next;
    logic [1:0]        status_reg, status_next;
    logic [MX-1:0]     bidx_reg, bidx_next;
    logic [MX:0]       head_reg [MX+1];

    logic              head_we;
    logic [MX:0]       head_wdata;
    logic              cfg_we;

    bpa_pkg::mem_we_t  we;
    logic [MX-1:0]     om_waddr, om_raddr, nx_waddr, pv_waddr, lk_raddr;
    logic [OM_W-1:0]   om_wdata, om_rdata;
    logic [MX:0]       nx_wdata, pv_wdata, nx_rdata, pv_rdata;

    logic [MX:0]       hd;
    logic [MX:0]       n_alloc;
    logic [HW-1:0]     rd_ord;
    logic              rd_flag;
    logic [MX-1:0]     align_mask;

    assign cfg_ready       = 1'b1;
    assign cfg_we          = cfg_valid;
    assign busy            = (state_reg != bpa_pkg::ST_IDLE);
    assign done            = done_reg;
    assign status          = status_reg;
    assign block_index_out = bidx_reg;
    assign pages_free      = ftot_reg;

    assign hd         = head_reg[ord_reg[HW-1:0]];
    assign n_alloc    = (cnt_reg == '0) ? (MX+1)'(1) : cnt_reg;
    assign rd_ord     = om_rdata[HW-1:0];
    assign rd_flag    = om_rdata[HW];
    assign align_mask = ~({MX{1'b1}} << rd_ord);

    bpa_store #(
        .MAX_POOL_ORDER(MAX_POOL_ORDER)
    ) u_store (
        .clk      (clk),
        .we       (we),
        .om_waddr (om_waddr),
        .om_wdata (om_wdata),
        .om_raddr (om_raddr),
        .om_rdata (om_rdata),
        .nx_waddr (nx_waddr),
        .nx_wdata (nx_wdata),
        .pv_waddr (pv_waddr),
        .pv_wdata (pv_wdata),
        .lk_raddr (lk_raddr),
        .nx_rdata (nx_rdata),
        .pv_rdata (pv_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bpa_pkg::ST_CLEAR;
            op_reg     <= 1'b0;
            k_reg      <= '0;
            ord_reg    <= '0;
            po_reg     <= HW'(RST_ORD);
            ftot_reg   <= (MX+1)'(1) << RST_ORD;
            clr_reg    <= '0;
            done_reg   <= 1'b0;
            status_reg <= bpa_pkg::STATUS_OK;
            for (int i = 0; i <= MX; i++)
            begin
                head_reg[i] <= (i == RST_ORD) ? '0 : NIL;
            end
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            k_reg      <= k_next;
            ord_reg    <= ord_next;
            po_reg     <= po_next;
            ftot_reg   <= ftot_next;
            clr_reg    <= clr_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            if (cfg_we)
            begin
                for (int i = 0; i <= MX; i++)
                begin
                    head_reg[i] <= (HW'(i) == po_next) ? '0 : NIL;
                end
            end
            else if (head_we)
            begin
                head_reg[ord_reg[HW-1:0]] <= head_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        blk_reg  <= blk_next;
        pg_reg   <= pg_next;
        cur_reg  <= cur_next;
        bud_reg  <= bud_next;
        bidx_reg <= bidx_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        cnt_next    = cnt_reg;
        blk_next    = blk_reg;
        k_next      = k_reg;
        ord_next    = ord_reg;
        pg_next     = pg_reg;
        cur_next    = cur_reg;
        bud_next    = bud_reg;
        po_next     = po_reg;
        ftot_next   = ftot_reg;
        clr_next    = clr_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        bidx_next   = bidx_reg;
        head_we     = 1'b0;
        head_wdata  = hd;
        we          = '0;
        om_waddr    = cur_reg;
        om_wdata    = '0;
        om_raddr    = blk_reg;
        nx_waddr    = cur_reg;
        nx_wdata    = NIL;
        pv_waddr    = cur_reg;
        pv_wdata    = NIL;
        lk_raddr    = pg_reg;

        case (state_reg)
            bpa_pkg::ST_CLEAR:
            begin
                we.om    = 1'b1;
                om_waddr = clr_reg;
                om_wdata = (clr_reg == '0) ? {1'b1, po_reg} : '0;
                if (clr_reg == '0)
                begin
                    we.nx    = 1'b1;
                    we.pv    = 1'b1;
                    nx_waddr = '0;
                    pv_waddr = '0;
                end
                clr_next = clr_reg + MX'(1);
                if (clr_reg == {MX{1'b1}})
                begin
                    state_next = bpa_pkg::ST_IDLE;
                end
            end
            bpa_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    op_next    = op;
                    cnt_next   = page_count;
                    blk_next   = block_index;
                    k_next     = '0;
                    state_next = bpa_pkg::ST_ORDER;
                end
            end
            bpa_pkg::ST_ORDER:
            begin
                // round up to the next power of two, one order per cycle
                if ((((MX+2)'(1)) << k_reg) < {1'b0, cnt_reg})
                begin
                    k_next = k_reg + KW'(1);
                end
                else
                begin
                    state_next = bpa_pkg::ST_DISPATCH;
                end
            end
            bpa_pkg::ST_DISPATCH:
            begin
                if (op_reg == bpa_pkg::OP_ALLOC)
                begin
                    if (n_alloc > ftot_reg)
                    begin
                        status_next = bpa_pkg::STATUS_NO_SPACE;
                        bidx_next   = '0;
                        done_next   = 1'b1;
                        state_next  = bpa_pkg::ST_IDLE;
                    end
                    else
                    begin
                        ord_next   = k_reg;
                        state_next = bpa_pkg::ST_A_SCAN;
                    end
                end
                else if ((blk_reg >> po_reg) != '0)
                begin
                    status_next = bpa_pkg::STATUS_REJECT;
                    bidx_next   = '0;
                    done_next   = 1'b1;
                    state_next  = bpa_pkg::ST_IDLE;
                end
                else
                begin
                    om_raddr   = blk_reg;
                    state_next = bpa_pkg::ST_F_CHECK;
                end
            end
            bpa_pkg::ST_A_SCAN:
            begin
                if (ord_reg > KW'(po_reg))
                begin
                    status_next = bpa_pkg::STATUS_NO_SPACE;
                    bidx_next   = '0;
                    done_next   = 1'b1;
                    state_next  = bpa_pkg::ST_IDLE;
                end
                else if (hd[MX])
                begin
                    ord_next = ord_reg + KW'(1);
                end
                else
                begin
                    pg_next    = hd[MX-1:0];
                    lk_raddr   = hd[MX-1:0];
                    state_next = bpa_pkg::ST_RM_WRITE;
                end
            end
            bpa_pkg::ST_RM_WRITE:
            begin
                // unlink using the prev and next read last cycle
                if (!pv_rdata[MX])
                begin
                    we.nx    = 1'b1;
                    nx_waddr = pv_rdata[MX-1:0];
                    nx_wdata = nx_rdata;
                end
                else
                begin
                    head_we    = 1'b1;
                    head_wdata = nx_rdata;
                end
                if (!nx_rdata[MX])
                begin
                    we.pv    = 1'b1;
                    pv_waddr = nx_rdata[MX-1:0];
                    pv_wdata = pv_rdata;
                end
                state_next = (op_reg == bpa_pkg::OP_ALLOC) ? bpa_pkg::ST_A_SPLIT
                                                           : bpa_pkg::ST_F_CLR_BUD;
            end
            bpa_pkg::ST_A_SPLIT:
            begin
                if (ord_reg > k_reg)
                begin
                    cur_next   = pg_reg + (MX'(1) << (ord_reg - KW'(1)));
                    ord_next   = ord_reg - KW'(1);
                    state_next = bpa_pkg::ST_PUSH1;
                end
                else
                begin
                    state_next = bpa_pkg::ST_A_FINISH;
                end
            end
            bpa_pkg::ST_A_FINISH:
            begin
                we.om       = 1'b1;
                om_waddr    = pg_reg;
                om_wdata    = {1'b0, k_reg[HW-1:0]};
                ftot_next   = ftot_reg - (((MX+1)'(1)) << k_reg);
                status_next = bpa_pkg::STATUS_OK;
                bidx_next   = pg_reg;
                done_next   = 1'b1;
                state_next  = bpa_pkg::ST_IDLE;
            end
            bpa_pkg::ST_PUSH1:
            begin
                we.om      = 1'b1;
                om_waddr   = cur_reg;
                om_wdata   = {1'b1, ord_reg[HW-1:0]};
                we.nx      = 1'b1;
                nx_waddr   = cur_reg;
                nx_wdata   = hd;
                we.pv      = 1'b1;
                pv_waddr   = cur_reg;
                pv_wdata   = NIL;
                state_next = bpa_pkg::ST_PUSH2;
            end
            bpa_pkg::ST_PUSH2:
            begin
                if (!hd[MX])
                begin
                    we.pv    = 1'b1;
                    pv_waddr = hd[MX-1:0];
                    pv_wdata = {1'b0, cur_reg};
                end
                head_we    = 1'b1;
                head_wdata = {1'b0, cur_reg};
                if (op_reg == bpa_pkg::OP_ALLOC)
                begin
                    state_next = bpa_pkg::ST_A_SPLIT;
                end
                else
                begin
                    ftot_next   = ftot_reg + (((MX+1)'(1)) << k_reg);
                    status_next = bpa_pkg::STATUS_OK;
                    bidx_next   = cur_reg;
                    done_next   = 1'b1;
                    state_next  = bpa_pkg::ST_IDLE;
                end
            end
            bpa_pkg::ST_F_CHECK:
            begin
                if (rd_flag || (rd_ord > po_reg) || ((blk_reg & align_mask) != '0)
                    || (cnt_reg == '0) || (k_reg != KW'(rd_ord)))
                begin
                    status_next = bpa_pkg::STATUS_REJECT;
                    bidx_next   = '0;
                    done_next   = 1'b1;
                    state_next  = bpa_pkg::ST_IDLE;
                end
                else
                begin
                    ord_next   = KW'(rd_ord);
                    cur_next   = blk_reg;
                    state_next = bpa_pkg::ST_F_LOOP;
                end
            end
            bpa_pkg::ST_F_LOOP:
            begin
                if (ord_reg < KW'(po_reg))
                begin
                    bud_next   = cur_reg ^ (MX'(1) << ord_reg);
                    om_raddr   = cur_reg ^ (MX'(1) << ord_reg);
                    state_next = bpa_pkg::ST_F_BUD;
                end
                else
                begin
                    state_next = bpa_pkg::ST_PUSH1;
                end
            end
            bpa_pkg::ST_F_BUD:
            begin
                if ((KW'(rd_ord) != ord_reg) || !rd_flag)
                begin
                    state_next = bpa_pkg::ST_PUSH1;
                end
                else
                begin
                    lk_raddr   = bud_reg;
                    state_next = bpa_pkg::ST_RM_WRITE;
                end
            end
            bpa_pkg::ST_F_CLR_BUD:
            begin
                we.om      = 1'b1;
                om_waddr   = bud_reg;
                om_wdata   = '0;
                state_next = bpa_pkg::ST_F_CLR_CUR;
            end
            bpa_pkg::ST_F_CLR_CUR:
            begin
                we.om      = 1'b1;
                om_waddr   = cur_reg;
                om_wdata   = '0;
                cur_next   = cur_reg & bud_reg;
                ord_next   = ord_reg + KW'(1);
                state_next = bpa_pkg::ST_F_LOOP;
            end
            default:
            begin
                state_next = bpa_pkg::ST_IDLE;
            end
        endcase

        // pool set up again as one free block
        if (cfg_we)
        begin
            po_next    = (int'(cfg_data) > MX) ? HW'(MX) : HW'(cfg_data);
            ftot_next  = ((MX+1)'(1)) << po_next;
            clr_next   = '0;
            done_next  = 1'b0;
            state_next = bpa_pkg::ST_CLEAR;
        end
    end

endmodule
